// ===== rtl/amt_pkg.sv =====
// Package for the adaptive mean threshold block.
// Holds shared constants, register indexes and item types; no dependencies.
package amt_pkg;

   localparam int MAX_RADIUS_DEF = 8;
   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_HEIGHT_DEF = 1024;

   localparam int RADIUS_W  = 4;
   localparam int DIM_W     = 11;
   localparam int GRAY_W    = 8;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 2'd2;

   localparam logic [RADIUS_W-1:0] RADIUS_RST = 4'd1;
   localparam logic [DIM_W-1:0]    DIM_RST    = 11'd1024;

   localparam logic              REQ_FLUSH   = 1'b1;
   localparam logic [GRAY_W-1:0] BW_WHITE    = 8'd255;
   localparam logic [GRAY_W-1:0] BW_BLACK    = 8'd0;
   localparam int                MEAN_MARGIN = 2;

   typedef struct packed {
      logic              req_type;
      logic [GRAY_W-1:0] gray_value;
   } amt_req_type;

   typedef struct packed {
      logic [GRAY_W-1:0] bw_value;
      logic              frame_last;
   } amt_rsp_type;

endpackage

// ===== rtl/adaptive_mean_threshold_core.sv =====
// Adaptive mean threshold over a clipped box window, raster streaming.
// Depends on amt_pkg, amt_row_store and amt_divider.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/req_stall | amt_req_type
//   rsp     | out       | rsp_valid/rsp_stall | amt_rsp_type
//   csr     | in        | csr_valid/csr_ready | csr_index, csr_data
//
// An item with a result passes through S_PREP, S_COUNT, S_READ, S_WAIT,
// S_DIVGO, S_DIV and S_EMIT: the window is summed one pixel per cycle
// through the single read port of the row store, then the mean comes
// from a bit-serial divider.
// Reset is synchronous; the row store needs no clearing.
// A result waits in the output register while the next item is taken.
module adaptive_mean_threshold_core #(
   parameter int MAX_RADIUS = amt_pkg::MAX_RADIUS_DEF,
   parameter int MAX_WIDTH  = amt_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = amt_pkg::MAX_HEIGHT_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  amt_pkg::amt_req_type             req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output amt_pkg::amt_rsp_type             rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [amt_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [amt_pkg::DIM_W-1:0]        csr_data
);

   localparam int SLOTS   = 2 * MAX_RADIUS + 2;
   localparam int SW      = $clog2(SLOTS);
   localparam int CW      = $clog2(MAX_WIDTH);
   localparam int ADDR_W  = SW + CW;
   localparam int RADW    = $clog2(MAX_RADIUS + 1);
   localparam int WW      = $clog2(MAX_WIDTH + 1);
   localparam int HW      = $clog2(MAX_HEIGHT + 1);
   localparam int HRW     = $clog2(MAX_HEIGHT);
   localparam int IRW     = $clog2(MAX_HEIGHT + MAX_RADIUS + 3);
   localparam int MAXDIM  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
   localparam int XW      = $clog2(MAXDIM + 2 * MAX_RADIUS + 3);
   localparam int WIN_MAX = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
   localparam int CNTW    = $clog2(WIN_MAX + 1);
   localparam int SUMW    = $clog2(255 * WIN_MAX + 1);
   localparam int TW      = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_RADIUS * MAX_WIDTH
                                   + MAX_RADIUS + 2);
   localparam int GW      = amt_pkg::GRAY_W;

   typedef enum logic [2:0] {
      S_IDLE, S_PREP, S_COUNT, S_READ, S_WAIT, S_DIVGO, S_DIV, S_EMIT
   } state_type;

   state_type state_ff;

   logic [amt_pkg::RADIUS_W-1:0] radius_ff;
   logic [amt_pkg::DIM_W-1:0]    width_ff;
   logic [amt_pkg::DIM_W-1:0]    height_ff;

   logic [RADW-1:0] rad_eff;
   logic [WW-1:0]   w_eff;
   logic [HW-1:0]   h_eff;
   logic [TW-1:0]   lag;

   logic [CW-1:0]  in_col_ff;
   logic [IRW-1:0] in_row_ff;
   logic [SW-1:0]  in_slot_ff;
   logic [TW-1:0]  cnt_ff;
   logic [CW-1:0]  out_col_ff;
   logic [HRW-1:0] out_row_ff;
   logic [SW-1:0]  out_slot_ff;

   logic [XW-1:0]   r0, r1, c0, c1, row_diff, start_slot;
   logic [XW-1:0]   r1_ff, c0_ff, c1_ff, rows_ff, cols_ff;
   logic [XW-1:0]   cur_row_ff, cur_col_ff;
   logic [SW-1:0]   cur_slot_ff;
   logic            first_ff;
   logic            rd_valid_ff;
   logic            rd_center_ff;
   logic [CNTW-1:0] count_ff;
   logic [SUMW-1:0] sum_ff;
   logic [GW-1:0]   pix_ff;

   logic              accept;
   logic              frame_in;
   logic              is_flush;
   logic              csr_write;
   logic              csr_known;
   logic              wr_en;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [GW-1:0]     rd_data;
   logic              div_start;
   logic              div_done;
   logic [SUMW-1:0]   quotient;
   logic              out_last;
   logic              out_free;

   logic                 rsp_valid_ff;
   amt_pkg::amt_rsp_type rsp_data_ff;

   always_comb begin
      rad_eff = (32'(radius_ff) > MAX_RADIUS) ? RADW'(MAX_RADIUS) : RADW'(radius_ff);
      if (width_ff == '0) begin
         w_eff = WW'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(width_ff);
      end
      if (height_ff == '0) begin
         h_eff = HW'(1);
      end else if (32'(height_ff) > MAX_HEIGHT) begin
         h_eff = HW'(MAX_HEIGHT);
      end else begin
         h_eff = HW'(height_ff);
      end
      lag = TW'(32'(rad_eff) * 32'(w_eff) + 32'(rad_eff));
   end

   // a pending register write holds off the input
   assign req_stall = (state_ff != S_IDLE) || csr_valid;
   assign csr_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign csr_write = csr_valid && csr_ready;
   assign csr_known = (csr_index == amt_pkg::CSR_RADIUS) ||
                      (csr_index == amt_pkg::CSR_WIDTH) ||
                      (csr_index == amt_pkg::CSR_HEIGHT);
   assign frame_in  = (XW'(in_row_ff) < XW'(h_eff));
   assign is_flush  = (req_data.req_type == amt_pkg::REQ_FLUSH);
   assign wr_en     = accept && frame_in;
   assign rd_en     = (state_ff == S_READ);
   assign div_start = (state_ff == S_DIVGO);
   assign out_last  = (XW'(out_row_ff) == XW'(h_eff) - 1'b1) &&
                      (XW'(out_col_ff) == XW'(w_eff) - 1'b1);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      if (first_ff) begin
         rd_addr = {out_slot_ff, out_col_ff};
      end else begin
         rd_addr = {cur_slot_ff, cur_col_ff[CW-1:0]};
      end
   end

   always_comb begin
      r0 = (XW'(out_row_ff) > XW'(rad_eff)) ? XW'(out_row_ff) - XW'(rad_eff) : '0;
      r1 = (XW'(out_row_ff) + XW'(rad_eff) >= XW'(h_eff)) ? XW'(h_eff) - 1'b1
                                                         : XW'(out_row_ff) + XW'(rad_eff);
      c0 = (XW'(out_col_ff) > XW'(rad_eff)) ? XW'(out_col_ff) - XW'(rad_eff) : '0;
      c1 = (XW'(out_col_ff) + XW'(rad_eff) >= XW'(w_eff)) ? XW'(w_eff) - 1'b1
                                                         : XW'(out_col_ff) + XW'(rad_eff);
      row_diff = XW'(out_row_ff) - r0;
      if (XW'(out_slot_ff) >= row_diff) begin
         start_slot = XW'(out_slot_ff) - row_diff;
      end else begin
         start_slot = XW'(out_slot_ff) + XW'(SLOTS) - row_diff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         radius_ff    <= amt_pkg::RADIUS_RST;
         width_ff     <= amt_pkg::DIM_RST;
         height_ff    <= amt_pkg::DIM_RST;
         in_col_ff    <= '0;
         in_row_ff    <= '0;
         in_slot_ff   <= '0;
         cnt_ff       <= '0;
         out_col_ff   <= '0;
         out_row_ff   <= '0;
         out_slot_ff  <= '0;
         first_ff     <= 1'b0;
         rd_valid_ff  <= 1'b0;
         rd_center_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff  <= rd_en;
         rd_center_ff <= rd_en && first_ff;
         if (rd_valid_ff) begin
            if (rd_center_ff) begin
               pix_ff <= rd_data;
            end else begin
               sum_ff <= sum_ff + SUMW'(rd_data);
            end
         end
         if (rsp_valid_ff && !rsp_stall && (state_ff != S_EMIT)) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            S_IDLE: begin
               if (csr_write && csr_known) begin
                  case (csr_index)
                     amt_pkg::CSR_RADIUS: radius_ff <= csr_data[amt_pkg::RADIUS_W-1:0];
                     amt_pkg::CSR_WIDTH:  width_ff  <= csr_data;
                     default:             height_ff <= csr_data;
                  endcase
                  in_col_ff   <= '0;
                  in_row_ff   <= '0;
                  in_slot_ff  <= '0;
                  cnt_ff      <= '0;
                  out_col_ff  <= '0;
                  out_row_ff  <= '0;
                  out_slot_ff <= '0;
               end else if (accept && !(is_flush && frame_in)) begin
                  if (XW'(in_col_ff) + 1'b1 >= XW'(w_eff)) begin
                     in_col_ff  <= '0;
                     in_row_ff  <= in_row_ff + 1'b1;
                     in_slot_ff <= (in_slot_ff == SW'(SLOTS - 1)) ? '0 : in_slot_ff + 1'b1;
                  end else begin
                     in_col_ff <= in_col_ff + 1'b1;
                  end
                  cnt_ff <= cnt_ff + 1'b1;
                  if (cnt_ff >= lag) begin
                     state_ff <= S_PREP;
                  end
               end
            end
            S_PREP: begin
               r1_ff       <= r1;
               c0_ff       <= c0;
               c1_ff       <= c1;
               rows_ff     <= r1 - r0 + 1'b1;
               cols_ff     <= c1 - c0 + 1'b1;
               cur_row_ff  <= r0;
               cur_col_ff  <= c0;
               cur_slot_ff <= SW'(start_slot);
               sum_ff      <= '0;
               first_ff    <= 1'b1;
               state_ff    <= S_COUNT;
            end
            S_COUNT: begin
               count_ff <= CNTW'(rows_ff * cols_ff);
               state_ff <= S_READ;
            end
            S_READ: begin
               if (first_ff) begin
                  first_ff <= 1'b0;
               end else if (cur_col_ff == c1_ff) begin
                  cur_col_ff <= c0_ff;
                  if (cur_row_ff == r1_ff) begin
                     state_ff <= S_WAIT;
                  end else begin
                     cur_row_ff  <= cur_row_ff + 1'b1;
                     cur_slot_ff <= (cur_slot_ff == SW'(SLOTS - 1)) ? '0
                                                                      : cur_slot_ff + 1'b1;
                  end
               end else begin
                  cur_col_ff <= cur_col_ff + 1'b1;
               end
            end
            S_WAIT: begin
               state_ff <= S_DIVGO;
            end
            S_DIVGO: begin
               state_ff <= S_DIV;
            end
            S_DIV: begin
               if (div_done) begin
                  state_ff <= S_EMIT;
               end
            end
            S_EMIT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff.bw_value <=
                     ((SUMW + 1)'(pix_ff) + (SUMW + 1)'(amt_pkg::MEAN_MARGIN) >
                      (SUMW + 1)'(quotient)) ? amt_pkg::BW_WHITE : amt_pkg::BW_BLACK;
                  rsp_data_ff.frame_last <= out_last;
                  if (out_last) begin
                     in_col_ff   <= '0;
                     in_row_ff   <= '0;
                     in_slot_ff  <= '0;
                     cnt_ff      <= '0;
                     out_col_ff  <= '0;
                     out_row_ff  <= '0;
                     out_slot_ff <= '0;
                  end else if (XW'(out_col_ff) + 1'b1 >= XW'(w_eff)) begin
                     out_col_ff  <= '0;
                     out_row_ff  <= out_row_ff + 1'b1;
                     out_slot_ff <= (out_slot_ff == SW'(SLOTS - 1)) ? '0
                                                                      : out_slot_ff + 1'b1;
                  end else begin
                     out_col_ff <= out_col_ff + 1'b1;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   amt_row_store #(
      .ADDR_W (ADDR_W),
      .DATA_W (GW)
   ) u_row_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr ({in_slot_ff, in_col_ff}),
      .wr_data (req_data.gray_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   amt_divider #(
      .NUM_W (SUMW),
      .DEN_W (CNTW)
   ) u_divider (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .numerator   (sum_ff),
      .denominator (count_ff),
      .done        (div_done),
      .quotient    (quotient)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIV))
      else $error("divider finished outside the divide state");

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (count_ff != '0))
      else $error("window count is zero during divide");

   a_in_col_range: assert property (@(posedge clock) disable iff (reset)
      (XW'(in_col_ff) < XW'(w_eff)))
      else $error("input column beyond image width");
`endif

endmodule

// ===== rtl/amt_row_store.sv =====
// Pixel row store: one write port, one registered read port.
// Depends on nothing.
module amt_row_store #(
   parameter int ADDR_W = 15,
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [0:(2**ADDR_W)-1];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/amt_divider.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on nothing.
module amt_divider #(
   parameter int NUM_W = 17,
   parameter int DEN_W = 9
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numerator,
   input  logic [DEN_W-1:0] denominator,
   output logic             done,
   output logic [NUM_W-1:0] quotient
);

   localparam int STEP_W = $clog2(NUM_W + 1);

   logic [DEN_W-1:0]  rem_ff;
   logic [NUM_W-1:0]  quo_ff;
   logic [STEP_W-1:0] step_ff;
   logic              busy_ff;
   logic              done_ff;
   logic [DEN_W:0]    trial;

   assign trial = {rem_ff, quo_ff[NUM_W-1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= STEP_W'(NUM_W);
            rem_ff  <= '0;
            quo_ff  <= numerator;
         end else if (busy_ff) begin
            if (trial >= {1'b0, denominator}) begin
               rem_ff <= DEN_W'(trial - {1'b0, denominator});
               quo_ff <= {quo_ff[NUM_W-2:0], 1'b1};
            end else begin
               rem_ff <= trial[DEN_W-1:0];
               quo_ff <= {quo_ff[NUM_W-2:0], 1'b0};
            end
            step_ff <= step_ff - 1'b1;
            if (step_ff == STEP_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
